@@ rtl/core/mcst_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Timer bank package
// Shared types and constants of the timer bank core and its slot cells.
// ----------------------------------------------------------------------------
package mcst_pkg;

   localparam int unsigned NUM_SLOTS_DEFAULT = 16;
   localparam logic [31:0] NO_DEADLINE = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ACT_TICK   = 3'd0,
      ACT_ALLOC  = 3'd1,
      ACT_FREE   = 3'd2,
      ACT_START  = 3'd3,
      ACT_STOP   = 3'd4,
      ACT_QUERY  = 3'd5
   } action_type;

   localparam logic [1:0] ST_FREE    = 2'd0;
   localparam logic [1:0] ST_STOPPED = 2'd1;
   localparam logic [1:0] ST_RUNNING = 2'd2;

   localparam logic [1:0] ERR_OK     = 2'd0;
   localparam logic [1:0] ERR_STATE  = 2'd1;
   localparam logic [1:0] ERR_NOFREE = 2'd2;

   // Slot contents as they move around the ring of cells.
   typedef struct packed {
      logic [1:0]  state;
      logic        periodic;
      logic [31:0] delay;
      logic [31:0] start;
      logic [31:0] alert;
   } slot_type;

endpackage
`default_nettype wire

@@ rtl/core/mcst_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Timer bank slot cell
// One stage of the slot ring: holds one slot and passes it on when shifting.
// ----------------------------------------------------------------------------
module mcst_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift,
   input  wire mcst_pkg::slot_type slot_in,
   output mcst_pkg::slot_type     slot_out
);

   mcst_pkg::slot_type slot_ff;
   mcst_pkg::slot_type slot_in_w;

   always_comb begin
      slot_in_w = shift ? slot_in : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.state    <= mcst_pkg::ST_FREE;
         slot_ff.periodic <= 1'b0;
         slot_ff.start    <= '0;
         slot_ff.alert    <= '0;
      end else begin
         slot_ff.state    <= slot_in_w.state;
         slot_ff.periodic <= slot_in_w.periodic;
         slot_ff.start    <= slot_in_w.start;
         slot_ff.alert    <= slot_in_w.alert;
      end
      slot_ff.delay <= slot_in_w.delay;
   end

   assign slot_out = slot_ff;

endmodule
`default_nettype wire

@@ rtl/core/multi_channel_soft_timer_bank_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Timer bank core
// Bank of one-shot and periodic timer slots driven by tick and slot commands.
// ----------------------------------------------------------------------------
// Words enter on the req_ channel: tick, allocate, free, start, stop, query.
// Results leave on the rsp_ channel; the last word of one request carries
// rsp_last_of_run. Slots sit in a ring of cells. Every command or tick
// rotates the ring once, one slot reaching the head cell per cycle while the
// output register is free, where the control logic reads and rewrites it. A
// command's reply is loaded into the output register once the pass is over
// and the register is free; a new request is taken only after that. A tick
// marks its expiring slots during the pass and then sends one expiry word
// per cycle while the receiver takes them, lowest slot first, so that every
// word carries the final nearest deadline, and no word at all when nothing
// expires. An unused action gives no word; the block is ready again the next
// cycle. When the receiver stalls, the output register holds its word and no
// new request is taken until it leaves. Reset frees all slots, zeros the time
// and sets the nearest deadline to all ones; the block is then ready.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_bank_core #(
   parameter int unsigned NUM_SLOTS = mcst_pkg::NUM_SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic [3:0]  req_timer_id,
   input  wire logic [31:0] req_delay_ticks,
   input  wire logic        req_periodic,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_reply_kind,
   output logic [3:0]       rsp_slot_id,
   output logic [1:0]       rsp_error_code,
   output logic [1:0]       rsp_slot_status,
   output logic [31:0]      rsp_time_left,
   output logic [31:0]      rsp_nearest_deadline,
   output logic             rsp_last_of_run
);

   localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int unsigned USED = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;

   mcst_pkg::slot_type ring [NUM_SLOTS];
   mcst_pkg::slot_type head_new;
   logic               shift;

   // Cell k feeds cell k-1; cell 0 is the head, rewritten and fed to the tail.
   for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
      mcst_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .slot_in  ((k == NUM_SLOTS - 1) ? head_new : ring[(k + 1) % NUM_SLOTS]),
         .slot_out (ring[k])
      );
   end

   logic           busy_ff, busy_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [2:0]     act_ff, act_in;
   logic [3:0]     id_ff, id_in;
   logic [31:0]    dly_ff, dly_in;
   logic           per_ff, per_in;
   logic [31:0]    now_ff, now_in;
   logic [31:0]    ear_ff, ear_in;
   logic           earv_ff, earv_in;
   logic           found_ff, found_in;
   logic [3:0]     fslot_ff, fslot_in;
   logic [1:0]     err_ff, err_in;
   logic [1:0]     st_ff, st_in;
   logic [31:0]    left_ff, left_in;
   logic           pend_ff, pend_in;
   logic [3:0]     pid_ff, pid_in;
   logic [1:0]     pst_ff, pst_in;
   logic [15:0]    xmask_ff, xmask_in;
   logic [15:0]    xstop_ff, xstop_in;
   logic           ov_ff, ov_in;
   logic           okind_ff, okind_in;
   logic [3:0]     oid_ff, oid_in;
   logic [1:0]     oerr_ff, oerr_in, ost_ff, ost_in;
   logic [31:0]    oleft_ff, oleft_in, oear_ff, oear_in;
   logic           olast_ff, olast_in;

   mcst_pkg::slot_type h;
   logic [3:0]  hid;
   logic        in_use, last_idx, out_free, hit, expire, newear;
   logic [31:0] el, span, ear_cur;
   logic        earv_cur;
   logic [3:0]  xsel;
   logic [15:0] xrest;

   assign h   = ring[0];
   assign hid = 4'(idx_ff);
   assign last_idx = (idx_ff == IW'(NUM_SLOTS - 1));
   assign in_use   = (32'(idx_ff) < USED);
   assign out_free = !ov_ff || rsp_ready;
   assign hit      = (hid == id_ff) && in_use;
   assign el       = now_ff - h.start;
   assign span     = h.alert - h.start;
   assign req_ready = !busy_ff && !pend_ff && out_free;

   // Lowest slot still waiting for its expiry word.
   always_comb begin
      xsel = '0;
      for (int j = 15; j >= 0; j--) begin
         if (xmask_ff[j]) xsel = 4'(j);
      end
      xrest = xmask_ff & ~(16'd1 << xsel);
   end

   always_comb begin
      busy_in = busy_ff; idx_in = idx_ff; act_in = act_ff; id_in = id_ff;
      dly_in = dly_ff; per_in = per_ff; now_in = now_ff; ear_in = ear_ff;
      earv_in = earv_ff; found_in = found_ff; fslot_in = fslot_ff;
      err_in = err_ff; st_in = st_ff; left_in = left_ff;
      pend_in = pend_ff; pid_in = pid_ff; pst_in = pst_ff;
      xmask_in = xmask_ff; xstop_in = xstop_ff;
      ov_in = ov_ff && !rsp_ready; okind_in = okind_ff; oid_in = oid_ff;
      oerr_in = oerr_ff; ost_in = ost_ff; oleft_in = oleft_ff;
      oear_in = oear_ff; olast_in = olast_ff;
      head_new = h; shift = 1'b0; expire = 1'b0; newear = 1'b0;
      ear_cur = ear_ff; earv_cur = earv_ff;

      if (req_valid && req_ready) begin
         act_in = req_action; id_in = req_timer_id; dly_in = req_delay_ticks;
         per_in = req_periodic; idx_in = '0; found_in = 1'b0; fslot_in = '0;
         err_in = mcst_pkg::ERR_STATE; st_in = mcst_pkg::ST_FREE; left_in = '0;
         xmask_in = '0;
         busy_in = (req_action <= 3'(mcst_pkg::ACT_QUERY));
         if (req_action == 3'(mcst_pkg::ACT_TICK)) begin
            now_in = now_ff + 32'd1; earv_in = 1'b0;
            ear_in = mcst_pkg::NO_DEADLINE;
         end
         if (req_action == 3'(mcst_pkg::ACT_ALLOC)) err_in = mcst_pkg::ERR_NOFREE;
      end else if (pend_ff && out_free) begin
         // Reply words once the whole ring has been visited.
         pend_in = 1'b0; ov_in = 1'b1; okind_in = 1'b0; olast_in = 1'b1;
         oid_in = pid_ff; oerr_in = err_ff; ost_in = pst_ff; oleft_in = left_ff;
         oear_in = earv_ff ? ear_ff : mcst_pkg::NO_DEADLINE;
         if (act_ff == 3'(mcst_pkg::ACT_TICK)) begin
            okind_in = 1'b1;
            oid_in = xsel;
            oerr_in = mcst_pkg::ERR_OK;
            ost_in = xstop_ff[xsel] ? mcst_pkg::ST_STOPPED : mcst_pkg::ST_RUNNING;
            oleft_in = '0;
            xmask_in = xrest;
            olast_in = (xrest == '0);
            pend_in = (xrest != '0);
         end
      end else if (busy_ff && out_free && !pend_ff) begin
         shift = 1'b1;
         case (act_ff)
            3'(mcst_pkg::ACT_TICK): begin
               if (in_use && h.state == mcst_pkg::ST_RUNNING && el >= span) begin
                  expire = 1'b1;
                  if (h.periodic) begin
                     head_new.start = now_ff;
                     head_new.alert = now_ff + h.delay;
                  end else begin
                     head_new.state = mcst_pkg::ST_STOPPED;
                  end
               end
               if (in_use && head_new.state == mcst_pkg::ST_RUNNING) begin
                  newear = !earv_ff ||
                     ((ear_ff - head_new.start) > (head_new.alert - head_new.start));
                  if (newear) begin
                     ear_cur = head_new.alert; earv_cur = 1'b1;
                  end
               end
               ear_in = ear_cur; earv_in = earv_cur;
               if (expire) begin
                  xmask_in[hid] = 1'b1;
                  xstop_in[hid] = !h.periodic;
               end
            end
            3'(mcst_pkg::ACT_ALLOC): begin
               if (in_use && !found_ff && h.state == mcst_pkg::ST_FREE) begin
                  found_in = 1'b1; fslot_in = hid;
                  head_new.state = mcst_pkg::ST_STOPPED;
                  head_new.periodic = per_ff; head_new.delay = dly_ff;
               end
            end
            3'(mcst_pkg::ACT_FREE): begin
               if (hit) begin
                  if (h.state == mcst_pkg::ST_FREE) err_in = mcst_pkg::ERR_STATE;
                  else begin
                     err_in = mcst_pkg::ERR_OK; head_new.state = mcst_pkg::ST_FREE;
                  end
                  st_in = head_new.state;
               end
            end
            3'(mcst_pkg::ACT_START): begin
               if (hit) begin
                  if (h.state != mcst_pkg::ST_STOPPED) err_in = mcst_pkg::ERR_STATE;
                  else begin
                     err_in = mcst_pkg::ERR_OK;
                     head_new.state = mcst_pkg::ST_RUNNING;
                     head_new.start = now_ff;
                     head_new.alert = now_ff + h.delay;
                     if (!earv_ff || ((ear_ff - now_ff) > h.delay)) begin
                        ear_in = now_ff + h.delay; earv_in = 1'b1;
                     end
                  end
                  st_in = head_new.state;
               end
            end
            3'(mcst_pkg::ACT_STOP): begin
               if (hit) begin
                  if (h.state != mcst_pkg::ST_RUNNING) err_in = mcst_pkg::ERR_STATE;
                  else begin
                     err_in = mcst_pkg::ERR_OK; head_new.state = mcst_pkg::ST_STOPPED;
                  end
                  st_in = head_new.state;
               end
            end
            3'(mcst_pkg::ACT_QUERY): begin
               if (hit) begin
                  err_in = mcst_pkg::ERR_OK; st_in = h.state;
                  left_in = (el < span) ? (h.alert - now_ff) : 32'd0;
               end
            end
            default: ;
         endcase
         idx_in = idx_ff + IW'(1);
         if (last_idx) begin
            idx_in = '0;
            busy_in = 1'b0;
            pid_in = id_ff; pst_in = st_in; pend_in = 1'b1;
            case (act_ff)
               3'(mcst_pkg::ACT_TICK): begin
                  pend_in = (xmask_in != '0);
               end
               3'(mcst_pkg::ACT_ALLOC): begin
                  pid_in = found_in ? fslot_in : 4'd0;
                  err_in = found_in ? mcst_pkg::ERR_OK : mcst_pkg::ERR_NOFREE;
                  pst_in = found_in ? mcst_pkg::ST_STOPPED : mcst_pkg::ST_FREE;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; idx_ff <= '0; now_ff <= '0; pend_ff <= 1'b0;
         ear_ff <= mcst_pkg::NO_DEADLINE; earv_ff <= 1'b0; ov_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; idx_ff <= idx_in; now_ff <= now_in; pend_ff <= pend_in;
         ear_ff <= ear_in; earv_ff <= earv_in; ov_ff <= ov_in; found_ff <= found_in;
      end
      act_ff <= act_in; id_ff <= id_in; dly_ff <= dly_in; per_ff <= per_in;
      fslot_ff <= fslot_in; err_ff <= err_in; st_ff <= st_in; left_ff <= left_in;
      pid_ff <= pid_in; pst_ff <= pst_in; okind_ff <= okind_in; oid_ff <= oid_in;
      xmask_ff <= xmask_in; xstop_ff <= xstop_in;
      oerr_ff <= oerr_in; ost_ff <= ost_in; oleft_ff <= oleft_in;
      oear_ff <= oear_in; olast_ff <= olast_in;
   end

   assign rsp_valid            = ov_ff;
   assign rsp_reply_kind       = okind_ff;
   assign rsp_slot_id          = oid_ff;
   assign rsp_error_code       = oerr_ff;
   assign rsp_slot_status      = ost_ff;
   assign rsp_time_left        = oleft_ff;
   assign rsp_nearest_deadline = oear_ff;
   assign rsp_last_of_run      = olast_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_ready) else $error("request taken during a pass");
   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> idx_ff == '0) else $error("ring index off while idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result word dropped");
   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_nearest_deadline) &&
      $stable(rsp_slot_id) && $stable(rsp_last_of_run))
      else $error("result word changed while waiting");
`endif

endmodule
`default_nettype wire

@@ verif/timer_bank_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank checker
// Watches the request and response channels of the timer bank, keeps its own
// copy of the slot bank, and compares every response word with the oldest
// predicted word.
// ----------------------------------------------------------------------------
module timer_bank_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic [3:0]  req_timer_id,
   input  wire logic [31:0] req_delay_ticks,
   input  wire logic        req_periodic,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic        rsp_reply_kind,
   input  wire logic [3:0]  rsp_slot_id,
   input  wire logic [1:0]  rsp_error_code,
   input  wire logic [1:0]  rsp_slot_status,
   input  wire logic [31:0] rsp_time_left,
   input  wire logic [31:0] rsp_nearest_deadline,
   input  wire logic        rsp_last_of_run,
   output int               fail_count,
   output int               words_pending
);

   typedef struct packed {
      logic        kind;
      logic [3:0]  slot;
      logic [1:0]  err;
      logic [1:0]  status;
      logic [31:0] left;
      logic [31:0] nearest;
      logic        last;
   } timer_word_type;

   timer_word_type expected_words[$];

   logic [1:0]  bank_state[16];
   logic        bank_periodic[16];
   logic [31:0] bank_delay[16];
   logic [31:0] bank_start[16];
   logic [31:0] bank_alert[16];
   logic [31:0] now_ticks;
   logic [31:0] nearest_alert;
   logic        nearest_known;

   assign words_pending = expected_words.size();

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic void note_deadline(input int i);
      if (!nearest_known ||
          (nearest_alert - bank_start[i]) > (bank_alert[i] - bank_start[i])) begin
         nearest_alert = bank_alert[i];
         nearest_known = 1'b1;
      end
   endfunction

   // Applies one request to the bank copy and queues the words it causes.
   task automatic predict_request(input logic [2:0] act, input logic [3:0] id,
                                  input logic [31:0] dly, input logic per);
      timer_word_type batch[$];
      timer_word_type w;
      logic found;
      w = '0;
      if (act == mcst_pkg::ACT_TICK) begin
         now_ticks++;
         nearest_known = 1'b0;
         for (int i = 0; i < 16; i++) begin
            if (bank_state[i] != mcst_pkg::ST_RUNNING) continue;
            if ((now_ticks - bank_start[i]) >= (bank_alert[i] - bank_start[i])) begin
               if (bank_periodic[i]) begin
                  bank_start[i] = now_ticks;
                  bank_alert[i] = now_ticks + bank_delay[i];
               end else begin
                  bank_state[i] = mcst_pkg::ST_STOPPED;
               end
               w = '0;
               w.kind = 1'b1;
               w.slot = i[3:0];
               w.status = bank_state[i];
               batch.push_back(w);
            end
            if (bank_state[i] == mcst_pkg::ST_RUNNING) note_deadline(i);
         end
      end else if (act == mcst_pkg::ACT_ALLOC) begin
         found = 1'b0;
         for (int i = 0; i < 16 && !found; i++) begin
            if (bank_state[i] == mcst_pkg::ST_FREE) begin
               found = 1'b1;
               bank_state[i] = mcst_pkg::ST_STOPPED;
               bank_periodic[i] = per;
               bank_delay[i] = dly;
               w.slot = i[3:0];
               w.status = mcst_pkg::ST_STOPPED;
            end
         end
         if (!found) w.err = mcst_pkg::ERR_NOFREE;
         batch.push_back(w);
      end else if (act <= mcst_pkg::ACT_QUERY) begin
         w.slot = id;
         case (act)
            mcst_pkg::ACT_FREE: begin
               if (bank_state[id] == mcst_pkg::ST_FREE) w.err = mcst_pkg::ERR_STATE;
               else bank_state[id] = mcst_pkg::ST_FREE;
            end
            mcst_pkg::ACT_START: begin
               if (bank_state[id] != mcst_pkg::ST_STOPPED) begin
                  w.err = mcst_pkg::ERR_STATE;
               end else begin
                  bank_state[id] = mcst_pkg::ST_RUNNING;
                  bank_start[id] = now_ticks;
                  bank_alert[id] = now_ticks + bank_delay[id];
                  note_deadline(int'(id));
               end
            end
            mcst_pkg::ACT_STOP: begin
               if (bank_state[id] != mcst_pkg::ST_RUNNING) w.err = mcst_pkg::ERR_STATE;
               else bank_state[id] = mcst_pkg::ST_STOPPED;
            end
            default: begin
               if ((now_ticks - bank_start[id]) < (bank_alert[id] - bank_start[id]))
                  w.left = bank_alert[id] - now_ticks;
            end
         endcase
         w.status = bank_state[id];
         batch.push_back(w);
      end
      foreach (batch[k]) begin
         batch[k].nearest = nearest_known ? nearest_alert : mcst_pkg::NO_DEADLINE;
         batch[k].last = (k == batch.size() - 1);
         expected_words.push_back(batch[k]);
      end
   endtask

   always @(posedge clock) begin
      timer_word_type got;
      timer_word_type want;
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            bank_state[i] = mcst_pkg::ST_FREE;
            bank_periodic[i] = 1'b0;
            bank_delay[i] = '0;
            bank_start[i] = '0;
            bank_alert[i] = '0;
         end
         now_ticks = '0;
         nearest_alert = mcst_pkg::NO_DEADLINE;
         nearest_known = 1'b0;
         expected_words.delete();
         fail_count = 0;
      end else begin
         // Check the response before applying the request of the same edge.
         if (rsp_valid && rsp_ready) begin
            got = {rsp_reply_kind, rsp_slot_id, rsp_error_code, rsp_slot_status,
                   rsp_time_left, rsp_nearest_deadline, rsp_last_of_run};
            if (expected_words.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else begin
               want = expected_words.pop_front();
               if (got.kind != want.kind) report_mismatch("reply_kind");
               if (got.slot != want.slot) report_mismatch("slot_id");
               if (got.err != want.err) report_mismatch("error_code");
               if (got.status != want.status) report_mismatch("slot_status");
               if (got.left != want.left) report_mismatch("time_left");
               if (got.nearest != want.nearest) report_mismatch("nearest_deadline");
               if (got.last != want.last) report_mismatch("last_of_run");
            end
         end
         if (req_valid && req_ready)
            predict_request(req_action, req_timer_id, req_delay_ticks, req_periodic);
      end
   end

endmodule

@@ verif/multi_channel_soft_timer_bank_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank testbench
// Drives directed and random slot commands and ticks with random gaps and
// response stalls; the checker predicts and compares every response word.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_bank_core_tb;

   localparam int CYCLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = '0;
   logic [3:0]  req_timer_id = '0;
   logic [31:0] req_delay_ticks = '0;
   logic        req_periodic = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_reply_kind;
   logic [3:0]  rsp_slot_id;
   logic [1:0]  rsp_error_code;
   logic [1:0]  rsp_slot_status;
   logic [31:0] rsp_time_left;
   logic [31:0] rsp_nearest_deadline;
   logic        rsp_last_of_run;
   int          fail_count;
   int          words_pending;
   int          cycle_count = 0;
   int          stall_left = 0;
   logic        calm = 1'b0;

   always #6 clock = ~clock;

   multi_channel_soft_timer_bank_core uut (.*);

   timer_bank_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int gap_length();
      if (calm) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
   endfunction

   // Response stalls: mostly short, a few long.
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (calm) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (r < 3) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(10, 40);
      end else begin
         rsp_ready <= (r >= 30);
      end
   end

   task automatic send_word(input mcst_pkg::action_type act, input logic [3:0] id,
                            input logic [31:0] dly, input logic per);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_timer_id <= id;
      req_delay_ticks <= dly;
      req_periodic <= per;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic tick_run(input int n);
      repeat (n) send_word(mcst_pkg::ACT_TICK, 4'($urandom), $urandom, 1'($urandom));
   endtask

   initial begin
      logic [3:0] id;
      int pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: errors on an empty bank, then fill it past the top.
      send_word(mcst_pkg::ACT_FREE, 4'd0, '0, 1'b0);
      send_word(mcst_pkg::ACT_STOP, 4'd15, '0, 1'b0);
      for (int i = 0; i < 17; i++)
         send_word(mcst_pkg::ACT_ALLOC, '0,
                   i == 0 ? 32'd0 : (i == 1 ? 32'hFFFF_FFFF : i + 1), i[0]);
      send_word(mcst_pkg::ACT_START, 4'd0, '0, 1'b0);
      send_word(mcst_pkg::ACT_START, 4'd0, '0, 1'b0);
      send_word(mcst_pkg::ACT_START, 4'd1, '0, 1'b0);
      send_word(mcst_pkg::ACT_START, 4'd3, '0, 1'b0);
      send_word(mcst_pkg::ACT_QUERY, 4'd1, '0, 1'b0);
      tick_run(3);
      send_word(mcst_pkg::ACT_STOP, 4'd3, '0, 1'b0);
      send_word(mcst_pkg::ACT_FREE, 4'd5, '0, 1'b0);
      send_word(mcst_pkg::action_type'(3'd6), 4'd2, '0, 1'b0);
      send_word(mcst_pkg::action_type'(3'd7), 4'd2, '0, 1'b0);
      for (int i = 2; i < 16; i++) send_word(mcst_pkg::ACT_FREE, i[3:0], '0, 1'b0);
      send_word(mcst_pkg::ACT_ALLOC, '0, 32'd2, 1'b1);

      // Random: allocate small delays, start, tick a lot, stop, free, query and send unused actions.
      for (int n = 0; n < 165; n++) begin
         pick = $urandom_range(0, 99);
         calm = (n % 50) >= 40;
         id = 4'($urandom);
         if (pick < 35) begin
            tick_run(1);
         end else if (pick < 50) begin
            send_word(mcst_pkg::ACT_ALLOC, '0,
                      $urandom_range(0, 19) == 0 ? $urandom : $urandom_range(0, 8),
                      1'($urandom));
         end else if (pick < 70) begin
            send_word(mcst_pkg::ACT_START, id, '0, 1'b0);
         end else if (pick < 80) begin
            send_word(mcst_pkg::ACT_STOP, id, '0, 1'b0);
         end else if (pick < 88) begin
            send_word(mcst_pkg::ACT_FREE, id, '0, 1'b0);
         end else if (pick < 98) begin
            send_word(mcst_pkg::ACT_QUERY, id, '0, 1'b0);
         end else begin
            send_word(mcst_pkg::action_type'(3'($urandom_range(6, 7))), id, $urandom,
                      1'($urandom));
         end
      end
      req_valid <= 1'b0;
      calm = 1'b1;
      repeat (2) @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
